// ----- rtl/tpsd_pkg.sv -----
// ----------------------------------------------------------------------------
// Tile picture stream decoder package
// Shared constants, request codes and glyph transform helpers.
// ----------------------------------------------------------------------------
`default_nettype none
package tpsd_pkg;
   localparam int SPRITE_COUNT_DEF = 256;
   localparam int TILE_CELLS_DEF   = 768;
   localparam int MAX_WIDTH_DEF    = 32;
   localparam int MAX_HEIGHT_DEF   = 12;

   localparam logic [1:0] REQ_LOAD  = 2'd0;
   localparam logic [1:0] REQ_BYTE  = 2'd1;
   localparam logic [1:0] REQ_READ  = 2'd2;
   localparam logic [1:0] REQ_START = 2'd3;

   localparam logic [1:0] CSR_VERSION = 2'd0;
   localparam logic [1:0] CSR_WIDTH   = 2'd1;
   localparam logic [1:0] CSR_HEIGHT  = 2'd2;

   localparam logic [1:0] OP_COPY = 2'd0;
   localparam logic [1:0] OP_OR   = 2'd1;
   localparam logic [1:0] OP_AND  = 2'd2;
   localparam logic [1:0] OP_XOR  = 2'd3;

   // one rotation/mirror step of an 8x8 glyph
   function automatic logic [63:0] turn_glyph(input logic [63:0] g, input logic [2:0] kind);
      logic [63:0] t;
      t = '0;
      for (int i = 0; i < 8; i++) begin
         for (int j = 0; j < 8; j++) begin
            if (kind == 3'd1 && g[8*j+i]) t[8*(7-i)+j] = 1'b1;
            if (kind == 3'd2 && g[8*i+j]) t[8*(7-i)+(7-j)] = 1'b1;
            if (kind == 3'd3 && g[8*j+i]) t[8*i+(7-j)] = 1'b1;
            if (kind == 3'd4 && g[8*i+j]) t[8*i+(7-j)] = 1'b1;
         end
      end
      return t;
   endfunction

   function automatic logic [63:0] shape_glyph(input logic [63:0] g, input logic [7:0] flags);
      logic [63:0] t;
      t = g;
      if (flags[5:4] != 2'd0) t = turn_glyph(t, {1'b0, flags[5:4]});
      if (flags[6]) t = turn_glyph(t, 3'd4);
      return turn_glyph(t, 3'd4);
   endfunction
endpackage
`default_nettype wire

// ----- rtl/tile_picture_stream_decoder.sv -----
// ----------------------------------------------------------------------------
// Tile picture stream decoder
// Two-phase picture stream decoder over sprite, tile and colour memories.
// ----------------------------------------------------------------------------
// A sprite load, a new-picture request and a stream byte that places nothing
// leave the decoder idle. A glyph placement reads eight sprite rows (one per
// cycle from the sprite memory) and then read-modify-writes every covered
// tile cell through the tile memory, with up to 256 cells per placement. An
// attribute run writes one colour cell after another. A read holds its result
// until it is taken. After reset a clearing pass zeroes the tile and colour
// memories before the first request is accepted.
`default_nettype none
module tile_picture_stream_decoder #(
   parameter int SPRITE_COUNT = tpsd_pkg::SPRITE_COUNT_DEF,
   parameter int TILE_CELLS   = tpsd_pkg::TILE_CELLS_DEF,
   parameter int MAX_WIDTH    = tpsd_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT   = tpsd_pkg::MAX_HEIGHT_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_type,
   input  wire logic [9:0]  index,
   input  wire logic [2:0]  row,
   input  wire logic [7:0]  data_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [63:0]      tile_rows,
   output logic [3:0]       ink,
   output logic [3:0]       paper,
   output logic             picture_done,
   input  wire logic        csr_write,
   input  wire logic [1:0]  csr_index,
   input  wire logic [5:0]  csr_data
);
   import tpsd_pkg::*;

   localparam int ATTR_CELLS = MAX_WIDTH * MAX_HEIGHT;
   localparam int SW = $clog2(SPRITE_COUNT * 8);
   localparam int TW = $clog2(TILE_CELLS);
   localparam int AW = (ATTR_CELLS > 1) ? $clog2(ATTR_CELLS) : 1;
   localparam int CW = TW + 1;

   typedef enum logic [3:0] {
      ST_CLEAR, ST_IDLE, ST_GLYPH, ST_GWAIT, ST_CELL_RD, ST_CELL_WR,
      ST_ATTR, ST_READ, ST_READ2, ST_RESP
   } state_type;

   typedef enum logic [2:0] {
      PH_OP, PH_COUNT, PH_CHAR, PH_OVL, PH_OVL_CHAR, PH_ATTR, PH_ATTR_COL, PH_DONE
   } phase_type;

   logic [7:0]  sprite_mem [SPRITE_COUNT*8];
   logic [63:0] tile_mem   [TILE_CELLS];
   logic [7:0]  colour_mem [ATTR_CELLS];

   state_type   state_ff, state_in;
   phase_type   phase_ff, phase_in;
   logic [2:0]  version_ff;
   logic [5:0]  width_ff;
   logic [3:0]  height_ff;
   logic [CW-1:0] cell_ff, cell_in;
   logic [8:0]  repeat_ff, repeat_in;
   logic [7:0]  last_ff, last_in;
   logic [7:0]  header_ff, header_in;
   logic [1:0]  combine_ff, combine_in;
   logic [5:0]  ax_ff, ax_in;
   logic [3:0]  ay_ff, ay_in;
   logic [7:0]  colour_ff, colour_in;

   // placement job
   logic [7:0]  pg_ff, pg_in;
   logic [7:0]  pflags_ff, pflags_in;
   logic [CW:0] pcell_ff, pcell_in;
   logic [8:0]  pleft_ff, pleft_in;
   logic        go_place;
   logic [3:0]  gcnt_ff;
   logic [63:0] glyph_ff;
   logic [7:0]  srd_ff;
   logic [63:0] trd_ff;
   logic [7:0]  crd_ff;
   logic [8:0]  aleft_ff, aleft_in;
   logic        go_attr;
   logic [9:0]  ridx_ff;
   logic [63:0] rows_ff;
   logic [3:0]  ink_ff, paper_ff;
   logic        done_ff;
   logic        rsp_valid_ff;
   logic [CW-1:0] clr_ff;

   logic [5:0]  ew;
   logic [3:0]  eh;
   logic [9:0]  area;
   logic        accept;
   logic [7:0]  b;
   logic [8:0]  ch;
   logic [63:0] shaped;
   logic [63:0] merged;
   logic [9:0]  aidx;
   logic [5:0]  ax_nx;
   logic [3:0]  ay_nx;
   logic [7:0]  acol_code;

   always_comb begin
      ew = (width_ff == 6'd0) ? 6'd1 :
           (width_ff > 6'(MAX_WIDTH)) ? 6'(MAX_WIDTH) : width_ff;
      eh = (height_ff == 4'd0) ? 4'd1 :
           (height_ff > 4'(MAX_HEIGHT)) ? 4'(MAX_HEIGHT) : height_ff;
      area = 10'(ew * eh);
   end

   assign req_stall    = (state_ff != ST_IDLE);
   assign accept       = req_valid && !req_stall;
   assign rsp_valid    = rsp_valid_ff;
   assign tile_rows    = rows_ff;
   assign ink          = ink_ff;
   assign paper        = paper_ff;
   assign picture_done = done_ff;
   assign b            = data_byte;

   // colour code for the current attribute
   always_comb begin
      logic [3:0] i, p;
      if (version_ff > 3'd2) begin
         i = {colour_ff[6], colour_ff[2:0]};
         p = {colour_ff[6], colour_ff[5:3]};
      end else begin
         i = {colour_ff[3] || version_ff < 3'd2, colour_ff[6:4]};
         p = {colour_ff[3] || version_ff < 3'd2, colour_ff[2:0]};
      end
      acol_code = {p, i};
   end

   // parser
   always_comb begin
      logic [CW:0] ncell;
      phase_in   = phase_ff;
      cell_in    = cell_ff;
      repeat_in  = repeat_ff;
      last_in    = last_ff;
      header_in  = header_ff;
      combine_in = combine_ff;
      colour_in  = colour_ff;
      pg_in      = pg_ff;
      pflags_in  = pflags_ff;
      pcell_in   = pcell_ff;
      pleft_in   = pleft_ff;
      aleft_in   = aleft_ff;
      go_place   = 1'b0;
      go_attr    = 1'b0;
      ch         = '0;
      ncell      = {1'b0, cell_ff};
      if (accept && req_type == REQ_START) begin
         phase_in = PH_OP; cell_in = '0; repeat_in = 9'd1; last_in = '0;
         header_in = '0; combine_in = '0; colour_in = '0;
      end else if (accept && req_type == REQ_BYTE) begin
         unique case (phase_ff) inside
            PH_OP: begin
               if (!b[7]) begin
                  ch = {1'b0, b};
                  if (last_ff[7] && version_ff > 3'd2) ch = ch + 9'd128;
                  last_in = ch[7:0];
                  pg_in = ch[7:0]; pflags_in = '0;
                  pcell_in = {1'b0, cell_ff}; pleft_in = 9'd1; go_place = 1'b1;
                  ncell = {1'b0, cell_ff} + 1'b1;
                  cell_in = ncell[CW-1:0];
                  phase_in = (ncell >= (CW+1)'(area) || (ncell > (CW+1)'(767)))
                             ? PH_ATTR : PH_OP;
               end else begin
                  header_in = b; repeat_in = 9'd1;
                  phase_in = b[1] ? PH_COUNT : PH_CHAR;
               end
            end
            PH_COUNT: begin
               repeat_in = {1'b0, b} + 9'd1;
               phase_in = PH_CHAR;
            end
            PH_CHAR, PH_OVL_CHAR: begin
               if (phase_ff == PH_CHAR)
                  ch = {1'b0, b} + ((header_ff[0] && !b[7]) ? 9'd128 : 9'd0);
               else
                  ch = {1'b0, b} + (header_ff[0] ? 9'd128 : 9'd0);
               last_in = ch[8] ? 8'hff : ch[7:0];
               pg_in = ch[7:0];
               if (phase_ff == PH_CHAR)
                  pflags_in = (header_ff[3:2] != 2'd0) ? (header_ff & 8'hf3) : header_ff;
               else
                  pflags_in = (header_ff & 8'hf3) | {4'd0, combine_ff, 2'd0};
               pcell_in = {1'b0, cell_ff}; pleft_in = repeat_ff;
               go_place = !ch[8];
               if (header_ff[3:2] != 2'd0) begin
                  combine_in = header_ff[3:2];
                  phase_in = PH_OVL;
               end else begin
                  ncell = {1'b0, cell_ff} + (CW+1)'(repeat_ff);
                  cell_in = ncell[CW-1:0];
                  phase_in = (ncell >= (CW+1)'(area)) ? PH_ATTR : PH_OP;
               end
            end
            PH_OVL: begin
               if (!b[7]) begin
                  ch = {1'b0, b} + ((version_ff == 3'd4 && header_ff[0]) ? 9'd128 : 9'd0);
                  pg_in = ch[7:0]; pflags_in = header_ff & 8'h0c;
                  pcell_in = {1'b0, cell_ff}; pleft_in = repeat_ff; go_place = 1'b1;
                  ncell = {1'b0, cell_ff} + (CW+1)'(repeat_ff);
                  cell_in = ncell[CW-1:0];
                  phase_in = (ncell >= (CW+1)'(area)) ? PH_ATTR : PH_OP;
               end else begin
                  header_in = b;
                  phase_in = PH_OVL_CHAR;
               end
            end
            PH_ATTR: begin
               if (ay_ff >= eh) phase_in = PH_DONE;
               else if (b[7]) begin
                  if (version_ff >= 3'd3) begin
                     aleft_in = {2'd0, b[6:0]}; go_attr = (b[6:0] != 7'd0);
                  end else begin
                     repeat_in = {2'd0, b[6:0]} + 9'd1;
                     phase_in = PH_ATTR_COL;
                  end
               end else begin
                  colour_in = b; aleft_in = 9'd1; go_attr = 1'b1;
               end
            end
            PH_ATTR_COL: begin
               colour_in = b; phase_in = PH_ATTR;
               aleft_in = repeat_ff; go_attr = 1'b1;
            end
            PH_DONE: ;
            default: ;
         endcase
      end
      if (state_ff == ST_ATTR && ay_nx >= eh) phase_in = PH_DONE;
   end

   assign shaped = shape_glyph(glyph_ff, pflags_ff);

   always_comb begin
      case (pflags_ff[3:2])
         OP_OR:   merged = trd_ff | shaped;
         OP_AND:  merged = trd_ff & shaped;
         OP_XOR:  merged = trd_ff ^ shaped;
         default: merged = shaped;
      endcase
   end

   assign aidx  = 10'(ay_ff * ew) + 10'(ax_ff);
   always_comb begin
      ax_nx = ax_ff + 6'd1;
      ay_nx = ay_ff;
      if (ax_nx >= ew) begin
         ax_nx = '0;
         ay_nx = ay_ff + 4'd1;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR:   state_in = (clr_ff == CW'(TILE_CELLS - 1)) ? ST_IDLE : ST_CLEAR;
         ST_IDLE: begin
            if (accept) begin
               if (req_type == REQ_READ) state_in = ST_READ;
               else if (go_place) state_in = ST_GLYPH;
               else if (go_attr) state_in = ST_ATTR;
            end
         end
         ST_GLYPH:   state_in = (gcnt_ff == 4'd8) ? ST_GWAIT : ST_GLYPH;
         ST_GWAIT:   state_in = ST_CELL_RD;
         ST_CELL_RD: state_in = ST_CELL_WR;
         ST_CELL_WR: state_in = (pleft_ff == 9'd1) ? ST_IDLE : ST_CELL_RD;
         ST_ATTR:    state_in = (aleft_ff == 9'd1 || ay_nx >= eh) ? ST_IDLE : ST_ATTR;
         ST_READ:    state_in = ST_READ2;
         ST_READ2:   state_in = ST_RESP;
         ST_RESP:    state_in = rsp_stall ? ST_RESP : ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // memories
   always_ff @(posedge clock) begin
      if (accept && req_type == REQ_LOAD && index < 10'(SPRITE_COUNT))
         sprite_mem[SW'({index, row})] <= data_byte;
      srd_ff <= sprite_mem[SW'({pg_ff, gcnt_ff[2:0]})];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR)
         tile_mem[clr_ff[TW-1:0]] <= '0;
      else if (state_ff == ST_CELL_WR && pcell_ff < (CW+1)'(TILE_CELLS))
         tile_mem[pcell_ff[TW-1:0]] <= merged;
      trd_ff <= tile_mem[(state_ff == ST_READ) ? ridx_ff[TW-1:0] : pcell_ff[TW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_CLEAR && clr_ff < CW'(ATTR_CELLS))
         colour_mem[clr_ff[AW-1:0]] <= '0;
      else if (state_ff == ST_ATTR && aidx < 10'(ATTR_CELLS))
         colour_mem[aidx[AW-1:0]] <= acol_code;
      crd_ff <= colour_mem[ridx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR; clr_ff <= '0;
         phase_ff <= PH_OP; version_ff <= 3'd3; width_ff <= 6'd32; height_ff <= 4'd12;
         cell_ff <= '0; repeat_ff <= 9'd1; last_ff <= '0; header_ff <= '0;
         combine_ff <= '0; ax_ff <= '0; ay_ff <= '0; colour_ff <= '0;
         rsp_valid_ff <= 1'b0; gcnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_CLEAR) clr_ff <= clr_ff + 1'b1;
         if (csr_write) begin
            unique case (csr_index)
               CSR_VERSION: version_ff <= csr_data[2:0];
               CSR_WIDTH:   width_ff   <= csr_data;
               CSR_HEIGHT:  height_ff  <= csr_data[3:0];
               default: ;
            endcase
         end
         phase_ff <= phase_in; cell_ff <= cell_in; repeat_ff <= repeat_in;
         last_ff <= last_in; header_ff <= header_in; combine_ff <= combine_in;
         colour_ff <= colour_in;
         if (accept && req_type == REQ_START) begin
            ax_ff <= '0; ay_ff <= '0;
         end
         if (state_ff == ST_IDLE && go_place) gcnt_ff <= '0;
         else if (state_ff == ST_GLYPH) gcnt_ff <= gcnt_ff + 4'd1;
         if (state_ff == ST_ATTR) begin
            ax_ff <= ax_nx; ay_ff <= ay_nx;
         end
         if (state_ff == ST_READ2) begin
            rsp_valid_ff <= 1'b1;
            rows_ff  <= ({1'b0, ridx_ff} < 11'(TILE_CELLS)) ? trd_ff : '0;
            ink_ff   <= (ridx_ff < 10'(ATTR_CELLS)) ? crd_ff[3:0] : '0;
            paper_ff <= (ridx_ff < 10'(ATTR_CELLS)) ? crd_ff[7:4] : '0;
            done_ff  <= (phase_ff == PH_DONE);
         end else if (rsp_valid_ff && !rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pg_ff <= pg_in; pflags_ff <= pflags_in;
      if (state_ff == ST_IDLE) begin
         pcell_ff <= pcell_in; pleft_ff <= pleft_in; aleft_ff <= aleft_in;
      end else if (state_ff == ST_CELL_WR) begin
         pcell_ff <= pcell_ff + 1'b1; pleft_ff <= pleft_ff - 9'd1;
      end else if (state_ff == ST_ATTR) begin
         aleft_ff <= aleft_ff - 9'd1;
      end
      if (state_ff == ST_GLYPH && gcnt_ff != 4'd0)
         glyph_ff <= {srd_ff, glyph_ff[63:8]};
      if (accept && req_type == REQ_READ) ridx_ff <= index;
   end
endmodule
`default_nettype wire

// ----- rtl/tpsd_checker.sv -----
// ----------------------------------------------------------------------------
// Tile picture stream decoder checker
// Port-level checks bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module tpsd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_stall,
   input wire logic [1:0]  req_type,
   input wire logic        rsp_valid,
   input wire logic        rsp_stall,
   input wire logic [63:0] tile_rows,
   input wire logic [3:0]  ink
);
   import tpsd_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(tile_rows) && $stable(ink))
      else $error("response changed while stalled");

   a_busy_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_READ |=> !rsp_valid)
      else $error("response too early");

   a_no_resp: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type != REQ_READ |=> !rsp_valid)
      else $error("response without read");
endmodule

bind tile_picture_stream_decoder tpsd_checker u_tpsd_checker (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_stall(req_stall),
   .req_type(req_type), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .tile_rows(tile_rows), .ink(ink)
);
`default_nettype wire
